// ----- rtl/timed_note_glow_table_macros.svh -----
// Assertion macros used by the glow table top level.
`ifndef TIMED_NOTE_GLOW_TABLE_MACROS_SVH
`define TIMED_NOTE_GLOW_TABLE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TNGT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glow table check failed");

// Check that cons holds in the cycle after ante.
`define TNGT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glow table check failed");

`endif

// ----- rtl/tngt_pkg.sv -----
// Shared types and constants of the timed note glow table.
`timescale 1ns / 1ps
`default_nettype none

package tngt_pkg;

    localparam int NOTE_LOW      = 21;
    localparam int NOTE_HIGH     = 108;
    localparam int KEY_SPAN      = 88;
    localparam int PITCH_CLASSES = 12;
    localparam int HUE_STEP      = 21;
    localparam int LEVEL_BASE    = 30;
    localparam int LEVEL_FLOOR   = 10;

    localparam logic [15:0] DEFAULT_DURATION_RESET = 16'd200;
    localparam logic [15:0] MAX_DURATION_RESET     = 16'd8000;

    // Result word kinds
    localparam logic [1:0] KIND_STORED  = 2'd0;
    localparam logic [1:0] KIND_DROPPED = 2'd1;
    localparam logic [1:0] KIND_LIVE    = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    // Configuration register indexes
    localparam logic REG_DEFAULT_DURATION = 1'b0;
    localparam logic REG_MAX_DURATION     = 1'b1;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } step_op_t;

    typedef struct packed {
        logic [11:0] position;
        logic [7:0]  hue;
        logic [31:0] expiry;
        logic [7:0]  level;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/timed_note_glow_table.sv -----
// Top level of the timed note glow table: sequencer, config and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "timed_note_glow_table_macros.svh"

// Timed note glow table. Keeps up to CAPACITY glowing notes for a
// PANEL_WIDTH x PANEL_HEIGHT LED panel in an entry memory with one write
// and one read port, and works on one input word at a time; in_ready is
// high only while the sequencer is idle, but a finished result word may
// still wait in the output register while the next input word is taken.
// A note-on (cmd 0) is accepted first; then the note is mapped, the expiry
// is added through the shared 32-bit adder, the entry is appended (or the
// note dropped when the table is full) and the result word is loaded. In a
// tick (cmd 1) the scan reads one entry a cycle through the memory read
// port, judges each one in the cycle after its read, runs it through the
// shared subtract/decay unit and writes survivors back packed at the front
// of the table, then closes the scan; when none survive an empty result
// word is loaded instead, else the stream reads each survivor in
// S_STREAM_RD and loads it into the output register in S_STREAM_OUT,
// because the memory read is registered. Output back-pressure stalls each
// step that loads a result word. No clearing pass after reset: live_count
// alone bounds which entries are read. Configuration writes (cfg_we) are
// taken at any edge but belong to idle periods.
module timed_note_glow_table #(
    parameter int CAPACITY     = 16,
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    // input channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         cmd,
    input  wire [7:0]   note,
    input  wire [31:0]  glow_ms,
    input  wire [7:0]   velocity,
    input  wire [31:0]  now_ms,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  kind,
    output logic [11:0] position,
    output logic [7:0]  hue,
    output logic [7:0]  level,
    output logic        last,
    // configuration
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [15:0]  cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NOTE,
        S_SCAN,
        S_STREAM_RD,
        S_STREAM_OUT,
        S_EMPTY
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] live_count_reg, live_count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [11:0]   position_reg, position_next;
    logic [7:0]    hue_reg, hue_next;
    logic [7:0]    level_reg, level_next;
    logic          last_reg, last_next;
    logic [15:0]   default_duration_reg;
    logic [15:0]   max_duration_reg;

    // latched input word
    logic [7:0]  note_reg;
    logic [31:0] duration_reg;
    logic [7:0]  velocity_reg;
    logic [31:0] now_reg;

    logic        in_fire;
    logic        out_free;
    logic        full;
    logic [31:0] duration_sel;

    // note mapping
    logic [11:0] map_position;
    logic [7:0]  map_hue;
    logic [7:0]  map_level;

    // shared unit
    tngt_pkg::step_op_t step_op;
    logic [31:0] step_a;
    logic [31:0] step_b;
    logic [31:0] step_result;
    logic        step_expired;
    logic [7:0]  step_level;
    logic        keep;

    // entry memory
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    tngt_pkg::entry_t  ram_wdata;
    logic              ram_re;
    tngt_pkg::entry_t  ram_rdata;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (live_count_reg == CW'(CAPACITY));

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign position  = position_reg;
    assign hue       = hue_reg;
    assign level     = level_reg;
    assign last      = last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duration_reg <= tngt_pkg::DEFAULT_DURATION_RESET;
            max_duration_reg     <= tngt_pkg::MAX_DURATION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tngt_pkg::REG_DEFAULT_DURATION: default_duration_reg <= cfg_data;
                tngt_pkg::REG_MAX_DURATION:     max_duration_reg     <= cfg_data;
                default:                        default_duration_reg <= default_duration_reg;
            endcase
        end
    end

    // Hold the accepted input word for the whole item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            note_reg     <= note;
            duration_reg <= glow_ms;
            velocity_reg <= velocity;
            now_reg      <= now_ms;
        end
    end

    // Zero asks for the default; anything else is clamped to the maximum
    always_comb
    begin
        if (duration_reg == 32'd0)
        begin
            duration_sel = {16'd0, default_duration_reg};
        end
        else if (duration_reg < {16'd0, max_duration_reg})
        begin
            duration_sel = duration_reg;
        end
        else
        begin
            duration_sel = {16'd0, max_duration_reg};
        end
    end

    tngt_note_map #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_note_map (
        .note     (note_reg),
        .velocity (velocity_reg),
        .position (map_position),
        .hue      (map_hue),
        .level    (map_level)
    );

    // Note-on adds the expiry; the scan subtracts now from each expiry
    always_comb
    begin
        if (state_reg == S_NOTE)
        begin
            step_op = tngt_pkg::OP_ADD;
            step_a  = now_reg;
            step_b  = duration_sel;
        end
        else
        begin
            step_op = tngt_pkg::OP_SUB;
            step_a  = ram_rdata.expiry;
            step_b  = now_reg;
        end
    end

    tngt_step_unit u_step (
        .op        (step_op),
        .a         (step_a),
        .b         (step_b),
        .level_in  (ram_rdata.level),
        .result    (step_result),
        .expired   (step_expired),
        .level_out (step_level)
    );

    // Drop an entry only when it is both expired and dark
    assign keep = !(step_expired && (step_level == 8'd0));

    // Memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = kept_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        case (state_reg)
            S_NOTE:
            begin
                ram_we             = out_free && !full;
                ram_waddr          = live_count_reg[AW-1:0];
                ram_wdata.position = map_position;
                ram_wdata.hue      = map_hue;
                ram_wdata.expiry   = step_result;
                ram_wdata.level    = map_level;
            end
            S_SCAN:
            begin
                ram_re          = (rd_idx_reg < live_count_reg);
                ram_we          = rd_valid_reg && keep;
                ram_wdata.level = step_level;
            end
            S_STREAM_RD:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tngt_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        live_count_next = live_count_reg;
        rd_idx_next     = rd_idx_reg;
        kept_next       = kept_reg;
        rd_valid_next   = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        position_next   = position_reg;
        hue_next        = hue_reg;
        level_next      = level_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_idx_next = '0;
                    kept_next   = '0;
                    state_next  = cmd ? S_SCAN : S_NOTE;
                end
            end

            S_NOTE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (full)
                    begin
                        kind_next     = tngt_pkg::KIND_DROPPED;
                        position_next = '0;
                        hue_next      = '0;
                        level_next    = '0;
                    end
                    else
                    begin
                        kind_next       = tngt_pkg::KIND_STORED;
                        position_next   = map_position;
                        hue_next        = map_hue;
                        level_next      = map_level;
                        live_count_next = live_count_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // Read one entry a cycle, judge the one read last cycle
                if (rd_idx_reg < live_count_reg)
                begin
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    rd_valid_next = 1'b1;
                end
                if (rd_valid_reg && keep)
                begin
                    kept_next = kept_reg + CW'(1);
                end
                if ((rd_idx_reg == live_count_reg) && !rd_valid_reg)
                begin
                    live_count_next = kept_reg;
                    rd_idx_next     = '0;
                    state_next      = (kept_reg == '0) ? S_EMPTY : S_STREAM_RD;
                end
            end

            S_STREAM_RD:
            begin
                state_next = S_STREAM_OUT;
            end

            S_STREAM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tngt_pkg::KIND_LIVE;
                    position_next  = ram_rdata.position;
                    hue_next       = ram_rdata.hue;
                    level_next     = ram_rdata.level;
                    last_next      = ((rd_idx_reg + CW'(1)) == live_count_reg);
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    state_next     = ((rd_idx_reg + CW'(1)) == live_count_reg) ?
                                     S_IDLE : S_STREAM_RD;
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tngt_pkg::KIND_EMPTY;
                    position_next  = '0;
                    hue_next       = '0;
                    level_next     = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            rd_idx_reg     <= '0;
            kept_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            position_reg   <= '0;
            hue_reg        <= '0;
            level_reg      <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            rd_idx_reg     <= rd_idx_next;
            kept_reg       <= kept_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            position_reg   <= position_next;
            hue_reg        <= hue_next;
            level_reg      <= level_next;
            last_reg       <= last_next;
        end
    end

    // The table never holds more than its capacity
    `TNGT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, live_count_reg <= CW'(CAPACITY))
    // Compaction never writes ahead of the read pointer
    `TNGT_ASSERT_SAME(a_kept_behind, clk, rst_n, state_reg == S_SCAN, kept_reg <= rd_idx_reg)
    // Streaming only reads entries that survived the scan
    `TNGT_ASSERT_SAME(a_stream_range, clk, rst_n, state_reg == S_STREAM_OUT,
                      rd_idx_reg < live_count_reg)
    // A stored note grows the table by one
    `TNGT_ASSERT_NEXT(a_note_append, clk, rst_n, (state_reg == S_NOTE) && out_free && !full,
                      live_count_reg == $past(live_count_reg) + CW'(1))

endmodule

`default_nettype wire

// ----- rtl/tngt_entry_ram.sv -----
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tngt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [AW-1:0]         waddr,
    input  tngt_pkg::entry_t     wdata,
    input  wire                  re,
    input  wire [AW-1:0]         raddr,
    output tngt_pkg::entry_t     rdata
);

    tngt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tngt_step_unit.sv -----
// Shared 32-bit add/subtract unit with expiry test and level decay.
`timescale 1ns / 1ps
`default_nettype none

module tngt_step_unit (
    input  tngt_pkg::step_op_t op,
    input  wire [31:0]         a,
    input  wire [31:0]         b,
    input  wire [7:0]          level_in,
    output logic [31:0]        result,
    output logic               expired,
    output logic [7:0]         level_out
);

    logic [9:0] level_x3;

    always_comb
    begin
        case (op)
            tngt_pkg::OP_ADD: result = a + b;
            tngt_pkg::OP_SUB: result = a - b;
            default:          result = a + b;
        endcase
    end

    // Expired once the signed time left is zero or negative
    assign expired = (result == 32'd0) || result[31];

    assign level_x3  = {2'b00, level_in} + {1'b0, level_in, 1'b0};
    assign level_out = (level_in > 8'(tngt_pkg::LEVEL_FLOOR)) ? level_x3[9:2] : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/tngt_note_map.sv -----
// Note to panel position, hue and start level.
`timescale 1ns / 1ps
`default_nettype none

module tngt_note_map #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire [7:0]   note,
    input  wire [7:0]   velocity,
    output logic [11:0] position,
    output logic [7:0]  hue,
    output logic [7:0]  level
);

    localparam int CLW      = $clog2(PANEL_WIDTH);
    localparam int ROW      = PANEL_HEIGHT / 2;
    localparam int ROW_BASE = ROW * PANEL_WIDTH;
    localparam bit ROW_ODD  = (ROW % 2) != 0;
    localparam int SPAN     = tngt_pkg::KEY_SPAN;

    logic [CLW-1:0] col_rom [SPAN];
    logic [7:0]     hue_rom [256];
    logic [6:0]     rel;
    logic [CLW-1:0] col;
    logic [CLW-1:0] col_eff;
    logic [31:0]    index_full;
    logic [9:0]     level_sum;

    for (genvar g = 0; g < SPAN; g++)
    begin : g_col
        assign col_rom[g] = CLW'((g * PANEL_WIDTH) / SPAN);
    end

    for (genvar h = 0; h < 256; h++)
    begin : g_hue
        assign hue_rom[h] = 8'((h % tngt_pkg::PITCH_CLASSES) * tngt_pkg::HUE_STEP);
    end

    // Clamp to the 88-key range for the position only
    always_comb
    begin
        if (note < 8'(tngt_pkg::NOTE_LOW))
        begin
            rel = 7'd0;
        end
        else if (note > 8'(tngt_pkg::NOTE_HIGH))
        begin
            rel = 7'(tngt_pkg::NOTE_HIGH - tngt_pkg::NOTE_LOW);
        end
        else
        begin
            rel = 7'(note - 8'(tngt_pkg::NOTE_LOW));
        end
    end

    assign col        = col_rom[rel];
    assign col_eff    = ROW_ODD ? (CLW'(PANEL_WIDTH - 1) - col) : col;
    assign index_full = 32'(ROW_BASE) + 32'(col_eff);
    assign position   = index_full[11:0];
    assign hue        = hue_rom[note];

    assign level_sum = {1'b0, velocity, 1'b0} + 10'(tngt_pkg::LEVEL_BASE);
    assign level     = (level_sum > 10'd255) ? 8'd255 : level_sum[7:0];

endmodule

`default_nettype wire
